// ----- hw/rtl/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ID_BITS       = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TIME_BITS     = 16;
    localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ARRIVE   = 2'd0,
        OP_RUN      = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_IDLE     = 2'd3
    } op_t;

    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] prio;
        logic [TIME_BITS-1:0]     rem;
    } entry_t;

    // per-cycle command broadcast to every queue cell
    typedef struct packed {
        logic ins;   // sorted insert of new entry
        logic push;  // push new entry onto head
        logic pop;   // remove head
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pps_cell.sv -----
`default_nettype none

module pps_cell (
    input  wire logic               clk,
    input  wire pps_pkg::cell_ctrl_t ctrl,
    input  wire pps_pkg::entry_t    new_entry,
    input  wire logic               occupied,
    input  wire pps_pkg::entry_t    left_entry,
    input  wire pps_pkg::entry_t    right_entry,
    input  wire logic               hit_in,
    output logic                    hit_out,
    output pps_pkg::entry_t         entry
);

    pps_pkg::entry_t entry_reg;
    pps_pkg::entry_t entry_next;
    logic            keep;
    logic            here;

    // insertion point is the first cell that is empty or not more urgent
    assign keep    = occupied && (entry_reg.prio < new_entry.prio);
    assign here    = ctrl.push | ~keep;
    assign hit_out = hit_in | here;
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.ins || ctrl.push)
        begin
            if (hit_in)
            begin
                entry_next = left_entry;
            end
            else if (here)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
`default_nettype none

// Preemptive priority scheduler: one running slot and a sorted ready queue
// held in a row of shift cells (lower priority value is more urgent).
// Command channel: a command transfers at a rising edge with start high and
// busy low. op selects arrival, run a time slice or dispatch; op 3 only
// reports the current state. busy is always low: every command finishes in
// the cycle it transfers, so one command per clock is sustained.
// Result channel: one result per command, on the result ports for exactly
// one cycle with done high, in the cycle after the command transfers
// (throughput 1 command per cycle). The ready queue compares the new
// entry in all cells at once and shifts them together, which sets this rate.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Reset (rst_n low, asynchronous) empties the slot and the queue and clears
// done; no clearing pass is needed, so commands are taken right away.
// dropped flags an arrival or preempted task lost to a full queue.
module preemptive_priority_scheduler (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          op,
    input  wire logic [pps_pkg::ID_BITS-1:0]         task_id,
    input  wire logic [pps_pkg::PRIORITY_BITS-1:0]   task_priority,
    input  wire logic [pps_pkg::TIME_BITS-1:0]       work_amount,
    input  wire logic [pps_pkg::TIME_BITS-1:0]       slice_amount,
    output logic                                     done,
    output logic                                     running_valid,
    output logic [pps_pkg::ID_BITS-1:0]              running_id,
    output logic                                     finished,
    output logic [pps_pkg::ID_BITS-1:0]              finished_id,
    output logic [pps_pkg::COUNT_BITS-1:0]           queue_count,
    output logic                                     dropped,
    output logic                                     busy_res
);

    localparam int QD = pps_pkg::QUEUE_DEPTH;
    localparam int CB = pps_pkg::COUNT_BITS;

    logic                              accept;
    pps_pkg::op_t                      op_code;
    pps_pkg::entry_t                   arr;
    pps_pkg::entry_t                   slot_reg;
    pps_pkg::entry_t                   slot_next;
    logic                              slot_valid_reg;
    logic                              slot_valid_next;
    logic [CB-1:0]                     count_reg;
    logic [CB-1:0]                     count_next;
    logic                              full;
    logic                              fin;
    logic                              drop;
    pps_pkg::cell_ctrl_t               ctrl;
    pps_pkg::entry_t                   cell_new;
    pps_pkg::entry_t                   cells [QD];
    logic [QD:0]                       hit;
    logic [QD-1:0]                     occupied;

    logic                              done_reg;
    logic                              running_valid_reg;
    logic [pps_pkg::ID_BITS-1:0]       running_id_reg;
    logic                              finished_reg;
    logic [pps_pkg::ID_BITS-1:0]       finished_id_reg;
    logic [CB-1:0]                     queue_count_reg;
    logic                              dropped_reg;
    logic                              busy_res_reg;

    assign busy    = 1'b0;
    assign accept  = start & ~busy;
    assign op_code = pps_pkg::op_t'(op);
    assign arr     = '{id: task_id, prio: task_priority, rem: work_amount};
    assign full    = (count_reg == CB'(QD));

    always_comb
    begin
        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        fin             = 1'b0;
        drop            = 1'b0;
        ctrl            = '0;
        cell_new        = arr;
        unique case (op_code)
            pps_pkg::OP_ARRIVE:
            begin
                if (!slot_valid_reg)
                begin
                    slot_valid_next = 1'b1;
                    slot_next       = arr;
                end
                else if (arr.prio < slot_reg.prio)
                begin
                    slot_next = arr;
                    cell_new  = slot_reg;
                    if (full)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + CB'(1);
                    end
                end
                else if (full)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    ctrl.ins   = 1'b1;
                    count_next = count_reg + CB'(1);
                end
            end
            pps_pkg::OP_RUN:
            begin
                if (slot_valid_reg)
                begin
                    if (slice_amount >= slot_reg.rem)
                    begin
                        fin             = 1'b1;
                        slot_valid_next = 1'b0;
                        slot_next       = '0;
                    end
                    else
                    begin
                        slot_next.rem = slot_reg.rem - slice_amount;
                    end
                end
            end
            pps_pkg::OP_DISPATCH:
            begin
                if (!slot_valid_reg && count_reg != '0)
                begin
                    slot_valid_next = 1'b1;
                    slot_next       = cells[0];
                    ctrl.pop        = 1'b1;
                    count_next      = count_reg - CB'(1);
                end
            end
            pps_pkg::OP_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
        if (!accept)
        begin
            ctrl = '0;
        end
    end

    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QD; gi++)
        begin : g_cell
            pps_pkg::entry_t left_e;
            pps_pkg::entry_t right_e;

            assign occupied[gi] = (CB'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_e = cell_new;
            end
            else
            begin : g_mid_l
                assign left_e = cells[gi-1];
            end

            if (gi == QD - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid_r
                assign right_e = cells[gi+1];
            end

            pps_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (cell_new),
                .occupied    (occupied[gi]),
                .left_entry  (left_e),
                .right_entry (right_e),
                .hit_in      (hit[gi]),
                .hit_out     (hit[gi+1]),
                .entry       (cells[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg          <= slot_next;
            running_id_reg    <= slot_valid_next ? slot_next.id : '0;
            finished_reg      <= fin;
            finished_id_reg   <= fin ? slot_reg.id : '0;
            queue_count_reg   <= count_next;
            dropped_reg       <= drop;
            busy_res_reg      <= slot_valid_next | (count_next != '0);
            running_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                slot_valid_reg <= slot_valid_next;
                count_reg      <= count_next;
            end
        end
    end

    assign done          = done_reg;
    assign running_valid = running_valid_reg;
    assign running_id    = running_id_reg;
    assign finished      = finished_reg;
    assign finished_id   = finished_id_reg;
    assign queue_count   = queue_count_reg;
    assign dropped       = dropped_reg;
    assign busy_res      = busy_res_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(QD))
        else $error("ready queue count exceeds depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("transferred command gave no result");

    a_fin_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> (!running_valid && finished_id == $past(slot_reg.id)))
        else $error("finished task still in slot");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (queue_count == CB'(QD)))
        else $error("drop reported with room in queue");

    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !running_valid) |-> (running_id == '0))
        else $error("empty slot reports an id");
`endif

endmodule

`default_nettype wire
